### rtl/core/cfb_pkg.sv
// Shared types, constants and the CRC-16/ARC byte update for the framed
// byte-stuffing encoder. No dependencies.
package cfb_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0]  FLAG_RESET   = 8'hA5;
   localparam logic [7:0]  ESCAPE_RESET = 8'hA6;
   localparam logic [7:0]  LIMIT_RESET  = 8'd120;
   localparam logic [7:0]  STUFF_MASK   = 8'h03;
   localparam logic [15:0] CRC_POLY     = 16'hA001;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_FLAG   = 2'd0;
   localparam logic [1:0] CSR_ESCAPE = 2'd1;
   localparam logic [1:0] CSR_LIMIT  = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       chunk_end;
      logic       frame_end;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] flag_value;
      logic [7:0] escape_value;
      logic [7:0] chunk_limit;
   } cfg_type;

   // One classified request, as handed from front to back
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        data_stuff;
      logic        open_frame;
      logic        chunk_mark;
      logic        last_byte;
      logic [15:0] crc;
      logic        crc_lo_stuff;
      logic        crc_hi_stuff;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // Reflected CRC-16, one byte, bitwise
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/core/crc16_escaped_frame_builder_core.sv
// Top level of the framed byte-stuffing encoder with CRC-16/ARC trailer.
// Uses cfb_pkg, cfb_front, cfb_queue and cfb_back.

// Each request is one raw payload byte plus a last-of-frame mark; the block
// answers with 1 to 8 encoded bytes on the result side, one per cycle while
// the sink pops. A frame opens with the flag byte, payload bytes equal to
// flag or escape go out as escape then (byte & 3), and the last request adds
// the stuffed CRC (low byte first) and a closing flag carrying chunk_end and
// frame_end. The single byte-per-cycle output stage of the back end puts out
// all bytes of one request before it takes the next. The front end takes a
// request every cycle while the descriptor queue (QUEUE_DEPTH entries) has
// room, so it keeps accepting while the back end is stalled by the sink.
// Configuration writes land at once and must only be made while the block
// is idle.
module crc16_escaped_frame_builder_core #(
   parameter int QUEUE_DEPTH = cfb_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   // request side
   input  logic             req_push,
   output logic             req_full,
   input  cfb_pkg::req_type req_data,
   // result side
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output cfb_pkg::rsp_type rsp_data,
   // configuration
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata
);

   cfb_pkg::cfg_type        cfg_ff;
   cfb_pkg::desc_type       front_desc;
   cfb_pkg::desc_type       head;
   cfb_pkg::queue_stat_type qstat;
   logic                    accept;
   logic                    head_pop;
   logic                    rsp_valid;

   // configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_value   <= cfb_pkg::FLAG_RESET;
         cfg_ff.escape_value <= cfb_pkg::ESCAPE_RESET;
         cfg_ff.chunk_limit  <= cfb_pkg::LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            cfb_pkg::CSR_FLAG:   cfg_ff.flag_value   <= csr_wdata;
            cfb_pkg::CSR_ESCAPE: cfg_ff.escape_value <= csr_wdata;
            cfb_pkg::CSR_LIMIT:  cfg_ff.chunk_limit  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_full = qstat.full;
   assign accept   = req_push && !qstat.full;

   // front: CRC, chunk count and frame state, one request per cycle while the queue has room
   cfb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .req    (req_data),
      .desc   (front_desc)
   );

   // decouples front and back so each can stall on its own
   cfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_desc),
      .pop       (head_pop),
      .head      (head),
      .stat      (qstat)
   );

   // back: byte serialiser with registered result stage
   cfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (!qstat.empty),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_pop    (rsp_pop),
      .rsp        (rsp_data)
   );

   assign rsp_empty = !rsp_valid;

endmodule

### rtl/core/cfb_front.sv
// Front end: accepts requests, runs the CRC, chunk count and frame state,
// and classifies each request into a descriptor. Uses cfb_pkg.
module cfb_front (
   input  logic              clock,
   input  logic              reset,
   input  cfb_pkg::cfg_type  cfg,
   input  logic              accept,
   input  cfb_pkg::req_type  req,
   output cfb_pkg::desc_type desc
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  count_ff, count_in;
   logic        inside_ff, inside_in;

   logic [15:0] crc_new;
   logic        stuff;
   logic [8:0]  sum;
   logic        mark;

   always_comb begin
      crc_new = cfb_pkg::crc16_byte(crc_ff, req.data_byte);
      stuff   = (req.data_byte == cfg.flag_value) || (req.data_byte == cfg.escape_value);
      // opening flag counts one, a stuffed byte two
      sum  = {1'b0, count_ff} + {8'd0, !inside_ff} + (stuff ? 9'd2 : 9'd1);
      mark = sum >= {1'b0, cfg.chunk_limit};

      desc.data_byte    = req.data_byte;
      desc.data_stuff   = stuff;
      desc.open_frame   = !inside_ff;
      desc.chunk_mark   = mark;
      desc.last_byte    = req.last_byte;
      desc.crc          = crc_new;
      desc.crc_lo_stuff = (crc_new[7:0] == cfg.flag_value) ||
                          (crc_new[7:0] == cfg.escape_value);
      desc.crc_hi_stuff = (crc_new[15:8] == cfg.flag_value) ||
                          (crc_new[15:8] == cfg.escape_value);

      crc_in    = crc_ff;
      count_in  = count_ff;
      inside_in = inside_ff;
      if (accept) begin
         if (req.last_byte) begin
            crc_in    = 16'd0;
            count_in  = 8'd0;
            inside_in = 1'b0;
         end else begin
            crc_in    = crc_new;
            count_in  = mark ? 8'd0 : sum[7:0];
            inside_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= 16'd0;
         count_ff  <= 8'd0;
         inside_ff <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         count_ff  <= count_in;
         inside_ff <= inside_in;
      end
   end

endmodule

### rtl/core/cfb_queue.sv
// Small register queue of descriptors between front and back.
// Uses cfb_pkg.
module cfb_queue #(
   parameter int DEPTH = cfb_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  cfb_pkg::desc_type       push_data,
   input  logic                    pop,
   output cfb_pkg::desc_type       head,
   output cfb_pkg::queue_stat_type stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   cfb_pkg::desc_type mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign stat.full  = (count_ff == DEPTH_C);
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/core/cfb_back.sv
// Back end: walks a descriptor's byte slots and puts out one encoded byte
// per cycle while the sink pops, into a registered result stage. Uses cfb_pkg.
module cfb_back (
   input  logic              clock,
   input  logic              reset,
   input  cfb_pkg::cfg_type  cfg,
   input  logic              head_valid,
   input  cfb_pkg::desc_type head,
   output logic              head_pop,
   output logic              rsp_valid,
   input  logic              rsp_pop,
   output cfb_pkg::rsp_type  rsp
);

   // Slot order of one request's bytes
   typedef enum logic [2:0] {
      PH_OPEN  = 3'd0,
      PH_ESC   = 3'd1,
      PH_DATA  = 3'd2,
      PH_LOESC = 3'd3,
      PH_LO    = 3'd4,
      PH_HIESC = 3'd5,
      PH_HI    = 3'd6,
      PH_CLOSE = 3'd7
   } phase_type;

   phase_type        phase_ff;
   logic             valid_ff;
   cfb_pkg::rsp_type out_ff;

   logic [7:0]       slots;
   phase_type        cur;
   logic             done;
   logic             advance;
   cfb_pkg::rsp_type nxt;

   always_comb begin
      slots[PH_OPEN]  = head.open_frame;
      slots[PH_ESC]   = head.data_stuff;
      slots[PH_DATA]  = 1'b1;
      slots[PH_LOESC] = head.last_byte && head.crc_lo_stuff;
      slots[PH_LO]    = head.last_byte;
      slots[PH_HIESC] = head.last_byte && head.crc_hi_stuff;
      slots[PH_HI]    = head.last_byte;
      slots[PH_CLOSE] = head.last_byte;

      // first slot in use at or after the current position
      cur = PH_DATA;
      for (int i = 7; i >= 0; i--) begin
         if (slots[i] && (3'(i) >= phase_ff)) begin
            cur = phase_type'(3'(i));
         end
      end
      done = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (slots[i] && (3'(i) > cur)) begin
            done = 1'b0;
         end
      end

      nxt.chunk_end = 1'b0;
      nxt.frame_end = 1'b0;
      nxt.run_last  = done;
      unique case (cur)
         PH_OPEN: nxt.out_byte = cfg.flag_value;
         PH_ESC, PH_LOESC, PH_HIESC: nxt.out_byte = cfg.escape_value;
         PH_DATA: begin
            nxt.out_byte  = head.data_stuff ? (head.data_byte & cfb_pkg::STUFF_MASK)
                                            : head.data_byte;
            nxt.chunk_end = head.chunk_mark;
         end
         PH_LO: nxt.out_byte = head.crc_lo_stuff ? (head.crc[7:0] & cfb_pkg::STUFF_MASK)
                                                 : head.crc[7:0];
         PH_HI: nxt.out_byte = head.crc_hi_stuff ? (head.crc[15:8] & cfb_pkg::STUFF_MASK)
                                                 : head.crc[15:8];
         PH_CLOSE: begin
            nxt.out_byte  = cfg.flag_value;
            nxt.chunk_end = 1'b1;
            nxt.frame_end = 1'b1;
         end
         default: nxt.out_byte = cfg.flag_value;
      endcase

      advance  = head_valid && (!valid_ff || rsp_pop);
      head_pop = advance && done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OPEN;
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= 1'b1;
         out_ff   <= nxt;
         phase_ff <= done ? PH_OPEN : phase_type'(cur + 3'd1);
      end else if (rsp_pop) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = out_ff;

endmodule

### tb/crc16_escaped_frame_builder_core_tb.sv
// Self-checking testbench for crc16_escaped_frame_builder_core: predicts the framed,
// byte-stuffed stream with CRC-16/ARC trailer and checks every result byte in order.
// Depends on cfb_pkg and the RTL of the block only.

class frame_scoreboard;
   // live copy of the configuration registers
   logic [7:0]  flag_byte;
   logic [7:0]  esc_byte;
   logic [7:0]  limit;
   // encoder state
   logic [15:0] crc;
   int unsigned chunk_fill;
   bit          frame_open;
   // bytes caused by the request being predicted
   cfb_pkg::rsp_type burst[8];
   int          burst_len;
   // expected bytes, oldest first
   cfb_pkg::rsp_type expected_bytes[$];
   int          errors;

   function new();
      flag_byte  = cfb_pkg::FLAG_RESET;
      esc_byte   = cfb_pkg::ESCAPE_RESET;
      limit      = cfb_pkg::LIMIT_RESET;
      crc        = 16'h0000;
      chunk_fill = 0;
      frame_open = 1'b0;
      errors     = 0;
   endfunction

   function void write_reg(logic [1:0] index, logic [7:0] value);
      case (index)
         cfb_pkg::CSR_FLAG:   flag_byte = value;
         cfb_pkg::CSR_ESCAPE: esc_byte  = value;
         cfb_pkg::CSR_LIMIT:  limit     = value;
         default: ;
      endcase
   endfunction

   // reflected CRC-16, LSB first
   function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ cfb_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function void emit(logic [7:0] b, logic ce, logic fe);
      burst[burst_len] = {b, ce, fe, 1'b0};
      burst_len++;
      chunk_fill++;
   endfunction

   function void emit_stuffed(logic [7:0] b);
      if (b == flag_byte || b == esc_byte) begin
         emit(esc_byte, 1'b0, 1'b0);
         emit(b & cfb_pkg::STUFF_MASK, 1'b0, 1'b0);
      end else begin
         emit(b, 1'b0, 1'b0);
      end
   endfunction

   // accepted request: work out every byte it will cause
   function void note_request(cfb_pkg::req_type r);
      burst_len = 0;
      if (!frame_open) begin
         emit(flag_byte, 1'b0, 1'b0);
         frame_open = 1'b1;
      end
      crc = crc_step(crc, r.data_byte);
      emit_stuffed(r.data_byte);
      // count is unbounded here, so it never wraps past the limit
      if (chunk_fill >= limit) begin
         burst[burst_len-1].chunk_end = 1'b1;
         chunk_fill = 0;
      end
      if (r.last_byte) begin
         emit_stuffed(crc[7:0]);
         emit_stuffed(crc[15:8]);
         emit(flag_byte, 1'b1, 1'b1);
         crc        = 16'h0000;
         chunk_fill = 0;
         frame_open = 1'b0;
      end
      burst[burst_len-1].run_last = 1'b1;
      for (int k = 0; k < burst_len; k++) expected_bytes.push_back(burst[k]);
   endfunction

   function void check_result(cfb_pkg::rsp_type got);
      cfb_pkg::rsp_type want;
      if (expected_bytes.size() == 0) begin
         $error("unexpected result: out_byte 0x%02h with nothing pending", got.out_byte);
         errors++;
         return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
         $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
         errors++;
      end
      if (got.chunk_end !== want.chunk_end) begin
         $error("chunk_end: expected %0b, got %0b", want.chunk_end, got.chunk_end);
         errors++;
      end
      if (got.frame_end !== want.frame_end) begin
         $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
         errors++;
      end
      if (got.run_last !== want.run_last) begin
         $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
         errors++;
      end
   endfunction
endclass

module crc16_escaped_frame_builder_core_tb;

   localparam int LONG_HOLD   = 200;  // receiver hold-off, cycles
   localparam int DRAIN_PAUSE = 12;   // settle time before touching registers
   localparam int TAIL_CYCLES = 24;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_push  = 1'b0;
   logic             req_full;
   cfb_pkg::req_type req_data  = '0;
   logic             rsp_empty;
   logic             rsp_pop   = 1'b0;
   cfb_pkg::rsp_type rsp_data;
   logic             csr_we    = 1'b0;
   logic [1:0]       csr_index = cfb_pkg::CSR_FLAG;
   logic [7:0]       csr_wdata = 8'h00;

   bit idle_on  = 1'b1;   // random gaps on both sides
   bit hold_rsp = 1'b0;   // one-shot request for the long receiver hold-off

   frame_scoreboard sb;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   crc16_escaped_frame_builder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Watchdog, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Result side: check what was popped at this edge, then choose pop for the next
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) sb.check_result(rsp_data);
         if (hold_rsp) begin
            // long hold-off so the descriptor queue fills and req_full rises
            hold_rsp   = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Offer one request and hold it until the block takes it. push stays high on
   // return, so back-to-back requests need no extra cycle.
   task automatic push_request(cfb_pkg::req_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      sb.note_request(r);
   endtask

   // Lower push and wait until every expected byte has been popped
   task automatic wait_drained();
      req_push <= 1'b0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // Only called with the block idle
   task automatic write_settings(logic [7:0] flag_v, logic [7:0] esc_v, logic [7:0] limit_v);
      csr_we    <= 1'b1;
      csr_index <= cfb_pkg::CSR_FLAG;
      csr_wdata <= flag_v;
      @(posedge clock);
      sb.write_reg(cfb_pkg::CSR_FLAG, flag_v);
      csr_index <= cfb_pkg::CSR_ESCAPE;
      csr_wdata <= esc_v;
      @(posedge clock);
      sb.write_reg(cfb_pkg::CSR_ESCAPE, esc_v);
      csr_index <= cfb_pkg::CSR_LIMIT;
      csr_wdata <= limit_v;
      @(posedge clock);
      sb.write_reg(cfb_pkg::CSR_LIMIT, limit_v);
      csr_we <= 1'b0;
   endtask

   // Payload byte biased towards the values that get stuffed
   function automatic logic [7:0] pick_payload();
      case ($urandom_range(0, 9))
         0, 1:    return sb.flag_byte;
         2:       return sb.esc_byte;
         3:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         4:       return sb.flag_byte ^ (8'h01 << $urandom_range(0, 7));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Two-byte frame whose CRC comes out as the given value (the map is one-to-one)
   function automatic logic [15:0] pair_for_crc(logic [15:0] target);
      for (int x = 0; x < 256; x++) begin
         for (int y = 0; y < 256; y++) begin
            if (sb.crc_step(sb.crc_step(16'h0000, 8'(x)), 8'(y)) == target)
               return {8'(x), 8'(y)};
         end
      end
      return 16'h0000;
   endfunction

   // Frames of random length and content; mostly short, the odd long one
   task automatic send_random_frames(int count);
      int span;
      span = 0;
      for (int k = 0; k < count; k++) begin
         if (span == 0) span = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30)
                                                           : $urandom_range(1, 6);
         span--;
         push_request({pick_payload(), span == 0});
      end
   endtask

   initial begin : stimulus
      logic [15:0] pair;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings: extremes, flag and escape stuffing, near misses
      push_request({8'h00, 1'b0});
      push_request({8'hFF, 1'b0});
      push_request({cfb_pkg::FLAG_RESET, 1'b0});
      push_request({cfb_pkg::ESCAPE_RESET, 1'b0});
      push_request({8'hA4, 1'b0});
      push_request({8'hA7, 1'b0});
      push_request({8'h55, 1'b1});
      // single-byte frames
      push_request({cfb_pkg::FLAG_RESET, 1'b1});
      push_request({8'h00, 1'b1});
      push_request({8'hFF, 1'b1});
      // CRC bytes that need stuffing: low = flag, high = escape
      pair = pair_for_crc({sb.esc_byte, sb.flag_byte});
      push_request({pair[15:8], 1'b0});
      push_request({pair[7:0], 1'b1});
      // low CRC byte = escape, high = zero
      pair = pair_for_crc({8'h00, sb.esc_byte});
      push_request({pair[15:8], 1'b0});
      push_request({pair[7:0], 1'b1});
      wait_drained();

      // Chunk limit of two, flag and escape at the byte extremes
      write_settings(8'h00, 8'hFF, 8'd2);
      send_random_frames(12);
      wait_drained();

      // Flag equal to escape, limit of zero: every payload byte ends a chunk
      write_settings(8'h7E, 8'h7E, 8'd0);
      send_random_frames(12);
      wait_drained();

      write_settings(8'hFF, 8'h00, 8'd1);
      send_random_frames(12);
      wait_drained();

      // Limit 255: drive the chunk count from 254 straight to 256 with a stuffed byte
      write_settings(cfb_pkg::FLAG_RESET, cfb_pkg::ESCAPE_RESET, 8'd255);
      if (sb.frame_open) push_request({8'h33, 1'b1});
      push_request({8'h11, 1'b0});
      for (int k = 0; k < 127; k++) begin
         push_request({(k % 2 == 0) ? sb.flag_byte : sb.esc_byte, 1'b0});
      end
      send_random_frames(3);
      wait_drained();

      // Random settings; receiver holds off at the start so the input side stalls
      write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(2, 12)));
      hold_rsp = 1'b1;
      send_random_frames(25);
      idle_on = 1'b0;
      send_random_frames(15);

      req_push <= 1'b0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
